// ===== hw/rtl/pfa_pkg.sv =====
// pfa_pkg: sizes, codes and controller types for the partition fit allocator.
// No dependencies; imported by every module of the block.
package pfa_pkg;

	localparam int PARTITIONS = 8;
	localparam int SIZE_BITS  = 16;
	localparam int PIDX_W     = $clog2(PARTITIONS);

	localparam int OP_W     = 2;
	localparam int PINDEX_W = 3;
	localparam int AMOUNT_W = 16;
	localparam int PART_W   = 3;
	localparam int REM_W    = 16;
	localparam int ALLOC_W  = 16;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage

// ===== hw/rtl/pfa_ctrl.sv =====
// pfa_ctrl: transaction sequencer for the partition fit allocator.
// Depends on pfa_pkg; drives pfa_dpath through ctrl_cmd_t.
module pfa_ctrl
	import pfa_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0] op,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  dp_status_t      status,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_nxt;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = (op == OP_ALLOC) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd.capture   = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.commit    = (state_q == ST_EXEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/pfa_dpath.sv =====
// pfa_dpath: partition tables, fit-policy scan unit and result register.
// Depends on pfa_pkg; sequenced by pfa_ctrl.
module pfa_dpath
	import pfa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          status,
	input  logic [OP_W-1:0]     op,
	input  logic [PINDEX_W-1:0] part_index,
	input  logic [AMOUNT_W-1:0] amount,
	output logic                ok,
	output logic [PART_W-1:0]   chosen_partition,
	output logic [REM_W-1:0]    part_remaining,
	output logic [ALLOC_W-1:0]  part_allocated
);

	logic [SIZE_BITS-1:0] cap_q   [PARTITIONS];
	logic [SIZE_BITS-1:0] rem_q   [PARTITIONS];
	logic [SIZE_BITS-1:0] alloc_q [PARTITIONS];
	logic [PIDX_W-1:0]    next_start_q;
	logic [1:0]           mode_q;

	logic [OP_W-1:0]      op_q;
	logic [PINDEX_W-1:0]  idx_q;
	logic [SIZE_BITS-1:0] amt_q;

	logic [PIDX_W-1:0]    k_q;
	logic                 found_q;
	logic [PIDX_W-1:0]    sel_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [SIZE_BITS-1:0] sel_alloc_q;

	logic [PIDX_W:0]      idx_sum;
	logic [PIDX_W-1:0]    cur_idx;
	logic                 fits;
	logic [SIZE_BITS-1:0] left;
	logic                 take;
	logic                 load_ok;
	logic [PIDX_W-1:0]    load_idx;
	logic [SIZE_BITS-1:0] alloc_new;

	logic                 res_ok;
	logic [PART_W-1:0]    res_part;
	logic [REM_W-1:0]     res_rem;
	logic [ALLOC_W-1:0]   res_alloc;

	// circular index for next fit, plain index otherwise
	always_comb begin
		idx_sum = {1'b0, k_q};
		if (mode_q == FIT_NEXT) begin
			idx_sum = {1'b0, next_start_q} + {1'b0, k_q};
			if (idx_sum >= (PIDX_W+1)'(PARTITIONS)) begin
				idx_sum = idx_sum - (PIDX_W+1)'(PARTITIONS);
			end
		end
		cur_idx = idx_sum[PIDX_W-1:0];
	end

	assign fits = (amt_q <= rem_q[cur_idx]);
	assign left = rem_q[cur_idx] - amt_q;

	always_comb begin
		take = 1'b0;
		unique case (mode_q)
			FIT_FIRST, FIT_NEXT: take = fits && !found_q;
			FIT_BEST:            take = fits && (!found_q || left < best_q);
			FIT_WORST:           take = fits && (!found_q || left >= best_q);
			default:             take = 1'b0;
		endcase
	end

	assign status.scan_last = (k_q == PIDX_W'(PARTITIONS - 1));
	assign load_ok          = (32'(idx_q) < PARTITIONS);
	assign load_idx         = PIDX_W'(idx_q);
	assign alloc_new        = sel_alloc_q + amt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FIT_FIRST;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			idx_q <= part_index;
			amt_q <= SIZE_BITS'(amount);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			k_q <= k_q + PIDX_W'(1);
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && take) begin
			sel_q       <= cur_idx;
			best_q      <= left;
			sel_alloc_q <= alloc_q[cur_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PARTITIONS; i++) begin
				cap_q[i]   <= '0;
				rem_q[i]   <= '0;
				alloc_q[i] <= '0;
			end
			next_start_q <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_LOAD) begin
				if (load_ok) begin
					cap_q[load_idx]   <= amt_q;
					rem_q[load_idx]   <= amt_q;
					alloc_q[load_idx] <= '0;
				end
			end else if (op_q == OP_ALLOC) begin
				if (found_q) begin
					rem_q[sel_q]   <= best_q;
					alloc_q[sel_q] <= alloc_new;
					if (mode_q == FIT_NEXT) begin
						next_start_q <= sel_q;
					end
				end
			end else if (op_q == OP_CLEAR) begin
				for (int i = 0; i < PARTITIONS; i++) begin
					rem_q[i]   <= cap_q[i];
					alloc_q[i] <= '0;
				end
				next_start_q <= '0;
			end
		end
	end

	always_comb begin
		res_ok    = 1'b0;
		res_part  = '0;
		res_rem   = '0;
		res_alloc = '0;
		unique case (op_q)
			OP_LOAD: begin
				if (load_ok) begin
					res_ok   = 1'b1;
					res_part = idx_q;
					res_rem  = REM_W'(amt_q);
				end
			end
			OP_ALLOC: begin
				if (found_q) begin
					res_ok    = 1'b1;
					res_part  = PART_W'(sel_q);
					res_rem   = REM_W'(best_q);
					res_alloc = ALLOC_W'(alloc_new);
				end
			end
			OP_CLEAR: begin
				res_ok  = 1'b1;
				res_rem = REM_W'(cap_q[0]);
			end
			default: res_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			ok               <= res_ok;
			chosen_partition <= res_part;
			part_remaining   <= res_rem;
			part_allocated   <= res_alloc;
		end
	end

endmodule

// ===== hw/rtl/partition_fit_allocator.sv =====
// partition_fit_allocator: fixed-partition allocator, first/best/worst/next fit.
// Depends on pfa_pkg, pfa_ctrl and pfa_dpath.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   tuser: op; tdata: part_index, amount
//   m_*       out  m_tvalid/m_tready   tuser: ok; tdata: chosen, remaining, allocated
//   cfg_*     in   cfg_wr_en           cfg_wr_data: fit_mode
//
// Allocate: an accept state, then a scan of all PARTITIONS partitions (one
// partition per cycle through the shared compare unit), then a commit state.
// Load, clear and unknown ops skip the scan. One transaction in flight.
// Reset clears all tables, next-fit start and fit_mode to zero.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits at commit until the register frees.
module partition_fit_allocator
	import pfa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [OP_W-1:0]     s_tuser,   // op
	input  logic [S_DATA_W-1:0] s_tdata,   // part_index[2:0], amount[18:3], zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                m_tuser,   // ok
	output logic [M_DATA_W-1:0] m_tdata    // chosen[2:0], remaining[18:3], allocated[34:19]
);

	ctrl_cmd_t             cmd;
	dp_status_t            status;
	logic [PART_W-1:0]     chosen_partition;
	logic [REM_W-1:0]      part_remaining;
	logic [ALLOC_W-1:0]    part_allocated;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pfa_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.cmd              (cmd),
		.status           (status),
		.op               (s_tuser),
		.part_index       (s_tdata[PINDEX_W-1:0]),
		.amount           (s_tdata[PINDEX_W+AMOUNT_W-1:PINDEX_W]),
		.ok               (m_tuser),
		.chosen_partition (chosen_partition),
		.part_remaining   (part_remaining),
		.part_allocated   (part_allocated)
	);

	assign m_tdata = {{(M_DATA_W-PART_W-REM_W-ALLOC_W){1'b0}},
		part_allocated, part_remaining, chosen_partition};

endmodule

// ===== tb/partition_fit_allocator_tb.sv =====
// Self-checking testbench for partition_fit_allocator: directed table, then random phases.
// Predicts first/best/worst/next fit placement internally; depends on pfa_pkg and the RTL.
`timescale 1ns / 1ps

module partition_fit_allocator_tb;
	import pfa_pkg::*;

	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_OFF = 12;

	typedef struct packed {
		logic                ok;
		logic [PART_W-1:0]   chosen;
		logic [REM_W-1:0]    remaining;
		logic [ALLOC_W-1:0]  allocated;
	} alloc_result_t;

	typedef struct {
		fit_mode_t              mode;
		logic [OP_W-1:0]        op;
		logic [PINDEX_W-1:0]    idx;
		logic [AMOUNT_W-1:0]    amount;
		bit                     typed;
		alloc_result_t          want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [1:0]          cfg_wr_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [OP_W-1:0]     s_tuser;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic                m_tuser;
	logic [M_DATA_W-1:0] m_tdata;

	// predicted block state
	logic [REM_W-1:0]    part_cap [PARTITIONS];
	logic [REM_W-1:0]    part_free [PARTITIONS];
	logic [ALLOC_W-1:0]  part_used [PARTITIONS];
	logic [PIDX_W-1:0]   next_start;
	fit_mode_t           fit_sel;

	alloc_result_t       pending_results [$];
	stim_row_t           directed_rows [$];
	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  ready_hold = 0;
	bit                  quiet = 1'b0;

	fit_mode_t phase_modes [PHASES] = '{FIT_FIRST, FIT_NEXT, FIT_BEST, FIT_WORST,
		FIT_NEXT, FIT_FIRST, FIT_WORST, FIT_BEST};

	partition_fit_allocator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tuser     (m_tuser),
		.m_tdata     (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver backpressure
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (quiet) begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(1, 50);
		end else begin
			m_tready <= 1'($urandom_range(0, 1));
			ready_hold <= gap_len() + 1;
		end
	end

	function automatic alloc_result_t apply_request(input logic [OP_W-1:0] op,
		input logic [PINDEX_W-1:0] idx, input logic [AMOUNT_W-1:0] amt);
		alloc_result_t r;
		int sel;
		int p;
		logic [REM_W-1:0] best;
		logic [REM_W-1:0] left;
		r = '0;
		sel = -1;
		best = '0;
		case (op)
			OP_LOAD: begin
				part_cap[idx] = amt;
				part_free[idx] = amt;
				part_used[idx] = '0;
				r = {1'b1, idx, amt, 16'd0};
			end
			OP_ALLOC: begin
				if (fit_sel == FIT_NEXT) begin
					for (int k = 0; k < PARTITIONS; k++) begin
						p = (next_start + k) % PARTITIONS;
						if (sel < 0 && amt <= part_free[p])
							sel = p;
					end
				end else begin
					for (int i = 0; i < PARTITIONS; i++) begin
						if (amt <= part_free[i]) begin
							left = part_free[i] - amt;
							if (sel < 0 || (fit_sel == FIT_BEST && left < best) ||
								(fit_sel == FIT_WORST && left >= best)) begin
								sel = i;
								best = left;
							end
						end
					end
				end
				if (sel >= 0) begin
					part_free[sel] = part_free[sel] - amt;
					part_used[sel] = part_used[sel] + amt;
					if (fit_sel == FIT_NEXT)
						next_start = sel[PIDX_W-1:0];
					r = {1'b1, sel[PART_W-1:0], part_free[sel], part_used[sel]};
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < PARTITIONS; i++) begin
					part_free[i] = part_cap[i];
					part_used[i] = '0;
				end
				next_start = '0;
				r = {1'b1, 3'd0, part_free[0], 16'd0};
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		alloc_result_t want;
		alloc_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[PART_W-1:0], m_tdata[PART_W+REM_W-1:PART_W],
				m_tdata[PART_W+REM_W+ALLOC_W-1:PART_W+REM_W]};
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: ok %0d chosen %0d", got.ok, got.chosen);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, got.ok);
					mismatches++;
				end
				if (got.chosen !== want.chosen) begin
					$error("chosen_partition: expected %0d, got %0d", want.chosen, got.chosen);
					mismatches++;
				end
				if (got.remaining !== want.remaining) begin
					$error("part_remaining: expected %0d, got %0d", want.remaining,
						got.remaining);
					mismatches++;
				end
				if (got.allocated !== want.allocated) begin
					$error("part_allocated: expected %0d, got %0d", want.allocated,
						got.allocated);
					mismatches++;
				end
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [PINDEX_W-1:0] idx,
		input logic [AMOUNT_W-1:0] amt, input bit typed, input alloc_result_t want);
		alloc_result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, amt, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = apply_request(op, idx, amt);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic sender_gap();
		int n;
		n = quiet ? 0 : gap_len();
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_fit_mode(input fit_mode_t m);
		drain();
		repeat (HOLD_OFF) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fit_sel = m;
	endtask

	task automatic add_row(input fit_mode_t m, input logic [OP_W-1:0] op,
		input logic [PINDEX_W-1:0] idx, input logic [AMOUNT_W-1:0] amt,
		input bit typed, input alloc_result_t want);
		stim_row_t row;
		row.mode = m;
		row.op = op;
		row.idx = idx;
		row.amount = amt;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	function automatic logic [AMOUNT_W-1:0] load_amount();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 6)
			return AMOUNT_W'($urandom_range(0, 65535));
		return AMOUNT_W'($urandom_range(16, 4096));
	endfunction

	function automatic logic [AMOUNT_W-1:0] request_amount();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 4)
			return AMOUNT_W'($urandom_range(0, 65535));
		return AMOUNT_W'($urandom_range(1, 1500));
	endfunction

	initial begin
		int r;
		logic [OP_W-1:0] op;
		logic [AMOUNT_W-1:0] amt;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		fit_sel = FIT_FIRST;
		next_start = '0;
		for (int i = 0; i < PARTITIONS; i++) begin
			part_cap[i] = '0;
			part_free[i] = '0;
			part_used[i] = '0;
		end

		add_row(FIT_FIRST, OP_ALLOC,   3'd0, 16'd0,     1'b1, {1'b1, 3'd0, 16'd0, 16'd0});
		add_row(FIT_FIRST, OP_ALLOC,   3'd5, 16'd1,     1'b1, {1'b0, 3'd0, 16'd0, 16'd0});
		add_row(FIT_FIRST, OP_UNKNOWN, 3'd7, 16'hFFFF,  1'b1, {1'b0, 3'd0, 16'd0, 16'd0});
		add_row(FIT_FIRST, OP_LOAD,    3'd0, 16'd100,   1'b1, {1'b1, 3'd0, 16'd100, 16'd0});
		add_row(FIT_FIRST, OP_LOAD,    3'd7, 16'hFFFF,  1'b1, {1'b1, 3'd7, 16'hFFFF, 16'd0});
		add_row(FIT_FIRST, OP_LOAD,    3'd3, 16'd500,   1'b1, {1'b1, 3'd3, 16'd500, 16'd0});
		add_row(FIT_FIRST, OP_LOAD,    3'd5, 16'd200,   1'b1, {1'b1, 3'd5, 16'd200, 16'd0});
		add_row(FIT_FIRST, OP_ALLOC,   3'd2, 16'd150,   1'b0, '0);
		add_row(FIT_FIRST, OP_ALLOC,   3'd7, 16'hFFFF,  1'b0, '0);
		add_row(FIT_FIRST, OP_ALLOC,   3'd0, 16'hFFFF,  1'b1, {1'b0, 3'd0, 16'd0, 16'd0});
		add_row(FIT_BEST,  OP_ALLOC,   3'd1, 16'd90,    1'b0, '0);
		add_row(FIT_BEST,  OP_ALLOC,   3'd0, 16'd200,   1'b0, '0);
		add_row(FIT_WORST, OP_ALLOC,   3'd6, 16'd10,    1'b0, '0);
		add_row(FIT_WORST, OP_ALLOC,   3'd0, 16'd0,     1'b0, '0);
		add_row(FIT_NEXT,  OP_ALLOC,   3'd4, 16'd5,     1'b0, '0);
		add_row(FIT_NEXT,  OP_ALLOC,   3'd0, 16'd5,     1'b0, '0);
		add_row(FIT_NEXT,  OP_CLEAR,   3'd0, 16'd0,     1'b1, {1'b1, 3'd0, 16'd100, 16'd0});
		add_row(FIT_NEXT,  OP_ALLOC,   3'd0, 16'd100,   1'b0, '0);
		add_row(FIT_NEXT,  OP_LOAD,    3'd2, 16'd0,     1'b1, {1'b1, 3'd2, 16'd0, 16'd0});
		add_row(FIT_NEXT,  OP_UNKNOWN, 3'd0, 16'd0,     1'b1, {1'b0, 3'd0, 16'd0, 16'd0});
		add_row(FIT_NEXT,  OP_CLEAR,   3'd7, 16'hFFFF,  1'b0, '0);
		add_row(FIT_NEXT,  OP_ALLOC,   3'd3, 16'hFFFF,  1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].mode != fit_sel)
				set_fit_mode(directed_rows[n].mode);
			send_item(directed_rows[n].op, directed_rows[n].idx, directed_rows[n].amount,
				directed_rows[n].typed, directed_rows[n].want);
			sender_gap();
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			set_fit_mode(phase_modes[ph]);
			quiet = (ph % 3 == 2);
			// fresh partition layout, then a random mix of requests
			for (int i = 0; i < PARTITIONS; i++) begin
				send_item(OP_LOAD, i[PINDEX_W-1:0], load_amount(), 1'b0, '0);
				sender_gap();
			end
			for (int n = 0; n < PHASE_ITEMS - PARTITIONS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					op = OP_ALLOC;
					amt = request_amount();
				end else if (r < 85) begin
					op = OP_LOAD;
					amt = load_amount();
				end else if (r < 93) begin
					op = OP_CLEAR;
					amt = AMOUNT_W'($urandom_range(0, 65535));
				end else begin
					op = OP_UNKNOWN;
					amt = AMOUNT_W'($urandom_range(0, 65535));
				end
				send_item(op, PINDEX_W'($urandom_range(0, PARTITIONS - 1)), amt, 1'b0, '0);
				sender_gap();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_dpath.sv
hw/rtl/partition_fit_allocator.sv
tb/partition_fit_allocator_tb.sv
